[rtl/eoa_pkg.sv]
// Package for the euler orientation axes core: the shared command structure,
// the rotator arctangent table and fixed-point constants.
// No dependencies.
package eoa_pkg;

    localparam int ROT_STEPS = 30;
    localparam logic signed [33:0] ROT_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;      // take deltas, update angles
        logic       rot_init;  // start rotator on angle sel
        logic       rot_step;  // one rotator iteration
        logic       rot_save;  // store rotator result
        logic [1:0] sel;       // angle index 0 pitch 1 yaw 2 roll
        logic [4:0] iter;
        logic       mul_go;    // issue one microprogram multiply
        logic [5:0] mop;       // multiply program counter
    } eoa_cmd_t;

    function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0:  atan_lut = 34'h20000000;
            5'd1:  atan_lut = 34'h12E4051D;
            5'd2:  atan_lut = 34'h09FB385B;
            5'd3:  atan_lut = 34'h051111D4;
            5'd4:  atan_lut = 34'h028B0D43;
            5'd5:  atan_lut = 34'h0145D7E1;
            5'd6:  atan_lut = 34'h00A2F61E;
            5'd7:  atan_lut = 34'h00517C55;
            5'd8:  atan_lut = 34'h0028BE53;
            5'd9:  atan_lut = 34'h00145F2E;
            5'd10: atan_lut = 34'h000A2F98;
            5'd11: atan_lut = 34'h000517CC;
            5'd12: atan_lut = 34'h00028BE6;
            5'd13: atan_lut = 34'h000145F3;
            5'd14: atan_lut = 34'h0000A2F9;
            5'd15: atan_lut = 34'h0000517C;
            5'd16: atan_lut = 34'h000028BE;
            5'd17: atan_lut = 34'h0000145F;
            5'd18: atan_lut = 34'h00000A2F;
            5'd19: atan_lut = 34'h00000517;
            5'd20: atan_lut = 34'h0000028B;
            5'd21: atan_lut = 34'h00000145;
            5'd22: atan_lut = 34'h000000A2;
            5'd23: atan_lut = 34'h00000051;
            5'd24: atan_lut = 34'h00000028;
            5'd25: atan_lut = 34'h00000014;
            5'd26: atan_lut = 34'h0000000A;
            5'd27: atan_lut = 34'h00000005;
            5'd28: atan_lut = 34'h00000002;
            5'd29: atan_lut = 34'h00000001;
            default: atan_lut = 34'h0;
        endcase
    endfunction

    // last step of the multiply program: axis rounding
    localparam int MOP_COUNT = 22;

endpackage

[rtl/eoa_ctrl.sv]
// Sequencer for the euler orientation axes core: walks load, three rotator
// passes and the multiply program, then waits to hand off the result. Uses eoa_pkg.
module eoa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_busy,
    output logic              idle,
    output logic              done,
    output eoa_pkg::eoa_cmd_t cmd
);
    import eoa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 2'd0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.iter   = cnt_reg[4:0] - 5'd1;
        cmd.mop    = cnt_reg;
        idle       = (state_reg == S_IDLE);
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ROT;
                    sel_next   = 2'd0;
                    cnt_next   = 6'd0;
                end
            end
            S_ROT:
            begin
                // count 0 initializes, 1..30 iterate, 31 saves
                if (cnt_reg == 6'd0)
                    cmd.rot_init = 1'b1;
                else if (cnt_reg <= 6'(ROT_STEPS))
                    cmd.rot_step = 1'b1;
                else
                    cmd.rot_save = 1'b1;
                if (cnt_reg == 6'(ROT_STEPS + 1))
                begin
                    cnt_next = 6'd0;
                    if (sel_reg == 2'd2)
                        state_next = S_MUL;
                    else
                        sel_next = sel_reg + 2'd1;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                if (cnt_reg == 6'(MOP_COUNT))
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

[rtl/eoa_datapath.sv]
// Datapath for the euler orientation axes core: angle registers, shared
// rotator, one shared multiplier, and the axis rounding. Uses eoa_pkg.
module eoa_datapath #(
    parameter int ANGLE_BITS = 16,
    parameter int AXIS_BITS  = 16
) (
    input  logic                        clk,
    input  eoa_pkg::eoa_cmd_t           cmd,
    input  logic                        rst_n,
    input  logic signed [15:0]          delta_x,
    input  logic signed [15:0]          delta_y,
    input  logic signed [15:0]          delta_z,
    input  logic [15:0]                 pitch_gain,
    input  logic [15:0]                 yaw_gain,
    input  logic [15:0]                 roll_gain,
    output logic [9*AXIS_BITS-1:0]      axes
);
    import eoa_pkg::*;

    localparam int SH = 32 - AXIS_BITS;

    logic [ANGLE_BITS-1:0] ang_reg [3];
    logic signed [33:0] rx_reg, ry_reg, rz_reg;
    logic               swap_reg;
    // sin/cos: index 0 pitch 1 yaw 2 roll
    logic signed [33:0] sn_reg [3];
    logic signed [33:0] cs_reg [3];
    // scratch registers for the multiply program
    logic signed [33:0] t_reg [12];
    logic signed [33:0] q_reg [4];
    logic [AXIS_BITS-1:0] ax_reg [9];

    function automatic logic [ANGLE_BITS-1:0] adv(input logic [ANGLE_BITS-1:0] a,
        input logic signed [15:0] d, input logic [15:0] g);
        logic signed [32:0] p;
        p = 33'(d) * $signed({1'b0, g});
        adv = a - ANGLE_BITS'(p >>> 8);
    endfunction

    // reset keeps the angles cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg[0] <= '0;
            ang_reg[1] <= '0;
            ang_reg[2] <= '0;
        end
        else if (cmd.load)
        begin
            ang_reg[0] <= adv(ang_reg[0], delta_y, pitch_gain);
            ang_reg[1] <= adv(ang_reg[1], delta_x, yaw_gain);
            ang_reg[2] <= adv(ang_reg[2], delta_z, roll_gain);
        end
    end

    logic [ANGLE_BITS-1:0] cur_ang;
    logic signed [33:0] phase;
    assign cur_ang = ang_reg[cmd.sel];
    assign phase = $signed({3'b0, cur_ang, (31 - ANGLE_BITS)'(0)});

    always_ff @(posedge clk)
    begin
        if (cmd.rot_init)
        begin
            rx_reg   <= ROT_GAIN;
            ry_reg   <= '0;
            swap_reg <= (phase >= ONE_Q30);
            rz_reg   <= (phase >= ONE_Q30) ? phase - ONE_Q30 : phase;
        end
        else if (cmd.rot_step)
        begin
            if (!rz_reg[33])
            begin
                rx_reg <= rx_reg - (ry_reg >>> cmd.iter);
                ry_reg <= ry_reg + (rx_reg >>> cmd.iter);
                rz_reg <= rz_reg - atan_lut(cmd.iter);
            end
            else
            begin
                rx_reg <= rx_reg + (ry_reg >>> cmd.iter);
                ry_reg <= ry_reg - (rx_reg >>> cmd.iter);
                rz_reg <= rz_reg + atan_lut(cmd.iter);
            end
        end
        if (cmd.rot_save)
        begin
            sn_reg[cmd.sel] <= swap_reg ? rx_reg : ry_reg;
            cs_reg[cmd.sel] <= swap_reg ? -ry_reg : rx_reg;
        end
    end

    // multiply program: operand select, one multiply, register result
    logic signed [33:0] ma, mb;
    logic signed [67:0] mp;
    logic signed [33:0] mr;
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mop)
            6'd0:  begin ma = cs_reg[2]; mb = cs_reg[1]; end // cr*cy
            6'd1:  begin ma = sn_reg[2]; mb = sn_reg[1]; end // sr*sy
            6'd2:  begin ma = sn_reg[2]; mb = cs_reg[1]; end // sr*cy
            6'd3:  begin ma = cs_reg[2]; mb = sn_reg[1]; end // cr*sy
            6'd4:  begin ma = t_reg[0]; mb = cs_reg[0]; end
            6'd5:  begin ma = t_reg[1]; mb = sn_reg[0]; end
            6'd6:  begin ma = t_reg[2]; mb = cs_reg[0]; end
            6'd7:  begin ma = t_reg[3]; mb = sn_reg[0]; end
            6'd8:  begin ma = t_reg[3]; mb = cs_reg[0]; end
            6'd9:  begin ma = t_reg[2]; mb = sn_reg[0]; end
            6'd10: begin ma = t_reg[0]; mb = sn_reg[0]; end
            6'd11: begin ma = t_reg[1]; mb = cs_reg[0]; end
            6'd13: begin ma = q_reg[1]; mb = q_reg[1]; end
            6'd14: begin ma = q_reg[2]; mb = q_reg[2]; end
            6'd15: begin ma = q_reg[3]; mb = q_reg[3]; end
            6'd16: begin ma = q_reg[1]; mb = q_reg[2]; end
            6'd17: begin ma = q_reg[1]; mb = q_reg[3]; end
            6'd18: begin ma = q_reg[2]; mb = q_reg[3]; end
            6'd19: begin ma = q_reg[0]; mb = q_reg[1]; end
            6'd20: begin ma = q_reg[0]; mb = q_reg[2]; end
            6'd21: begin ma = q_reg[0]; mb = q_reg[3]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    assign mp = 68'(ma) * 68'(mb);
    assign mr = 34'(mp >>> 30);

    // t index: 0 cr*cy,1 sr*sy,2 sr*cy,3 cr*sy,4..11 triples;
    // step 12 forms the quaternion, steps 13..21 fill pr_reg 0..8
    logic signed [33:0] pr_reg [9];
    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            if (cmd.mop < 6'd12)
                t_reg[cmd.mop[3:0]] <= mr;
            else if (cmd.mop == 6'd12)
            begin
                // quaternion from triples once all eight are stored
                q_reg[0] <= t_reg[4] + t_reg[5];
                q_reg[1] <= t_reg[6] - t_reg[7];
                q_reg[2] <= t_reg[8] + t_reg[9];
                q_reg[3] <= t_reg[10] - t_reg[11];
            end
            else if (cmd.mop < 6'(MOP_COUNT))
                pr_reg[4'(cmd.mop - 6'd13)] <= mr;
        end
    end

    function automatic logic [AXIS_BITS-1:0] to_axis(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + 36'(1 <<< (SH - 1))) >>> SH;
        if (r > 36'((1 <<< (AXIS_BITS - 1)) - 1))
            to_axis = {1'b0, {(AXIS_BITS - 1){1'b1}}};
        else if (r < -36'(1 <<< (AXIS_BITS - 1)))
            to_axis = {1'b1, {(AXIS_BITS - 1){1'b0}}};
        else
            to_axis = r[AXIS_BITS-1:0];
    endfunction

    logic signed [35:0] one36;
    assign one36 = 36'(ONE_Q30);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go && cmd.mop == 6'(MOP_COUNT))
        begin
            ax_reg[0] <= to_axis(one36 - 36'((36'(pr_reg[1]) + 36'(pr_reg[2])) <<< 1));
            ax_reg[1] <= to_axis(36'((36'(pr_reg[3]) + 36'(pr_reg[8])) <<< 1));
            ax_reg[2] <= to_axis(36'((36'(pr_reg[4]) - 36'(pr_reg[7])) <<< 1));
            ax_reg[3] <= to_axis(36'((36'(pr_reg[3]) - 36'(pr_reg[8])) <<< 1));
            ax_reg[4] <= to_axis(one36 - 36'((36'(pr_reg[0]) + 36'(pr_reg[2])) <<< 1));
            ax_reg[5] <= to_axis(36'((36'(pr_reg[5]) + 36'(pr_reg[6])) <<< 1));
            ax_reg[6] <= to_axis(36'((36'(pr_reg[4]) + 36'(pr_reg[7])) <<< 1));
            ax_reg[7] <= to_axis(36'((36'(pr_reg[5]) - 36'(pr_reg[6])) <<< 1));
            ax_reg[8] <= to_axis(one36 - 36'((36'(pr_reg[0]) + 36'(pr_reg[1])) <<< 1));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            axes[k*AXIS_BITS +: AXIS_BITS] = ax_reg[k];
    end
endmodule

[rtl/euler_orientation_axes_core.sv]
// Top level of the euler orientation axes core: stream ports, gain registers,
// output register. Instantiates eoa_ctrl and eoa_datapath; uses eoa_pkg.
//
// Each motion transaction updates pitch, yaw and roll and yields one
// transaction of nine Q1.14 axis entries. An item passes through a load step,
// three passes through one shared rotator (start, 30 iterations, save), 23 steps
// of the multiply program on one shared multiplier, and a hand-off step; the
// result is then registered in the output register. One item is in work
// at a time; a finished result waits in the output register while the next
// item is accepted, and the core holds in hand-off while that register is full
// and not being taken.
module euler_orientation_axes_core #(
    parameter int ANGLE_BITS = 16,
    parameter int AXIS_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,  // delta_x, delta_y, delta_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((9*AXIS_BITS+7)/8)*8-1:0] m_tdata, // forward xyz, up xyz, right xyz
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import eoa_pkg::*;

    localparam int OW = ((9*AXIS_BITS+7)/8)*8;
    localparam logic [1:0] REG_PITCH = 2'd0;
    localparam logic [1:0] REG_YAW   = 2'd1;
    localparam logic [1:0] REG_ROLL  = 2'd2;

    logic [15:0] pg_reg, yg_reg, rg_reg;
    logic        idle, done, in_fire;
    eoa_cmd_t    cmd;
    logic [9*AXIS_BITS-1:0] axes;
    logic        ov_reg;
    logic [OW-1:0] od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pg_reg <= 16'd256;
            yg_reg <= 16'd256;
            rg_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PITCH: pg_reg <= cfg_data;
                REG_YAW:   yg_reg <= cfg_data;
                REG_ROLL:  rg_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    eoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (ov_reg && !m_tready),
        .idle     (idle),
        .done     (done),
        .cmd      (cmd)
    );

    eoa_datapath #(
        .ANGLE_BITS (ANGLE_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .rst_n      (rst_n),
        .delta_x    (s_tdata[15:0]),
        .delta_y    (s_tdata[31:16]),
        .delta_z    (s_tdata[47:32]),
        .pitch_gain (pg_reg),
        .yaw_gain   (yg_reg),
        .roll_gain  (rg_reg),
        .axes       (axes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done)
            ov_reg <= 1'b1;
        else if (m_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            od_reg <= OW'(axes);
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
endmodule

[tb/sv/tb_euler_orientation_axes_core.sv]
// Testbench for euler_orientation_axes_core: random and directed motion transactions
// against a bit-exact predictor of angle accumulation, rotator and axis products.
// Depends on the RTL top level and eoa_pkg.
module tb_euler_orientation_axes_core;
    import eoa_pkg::*;

    localparam int AXIS_W = 16;
    localparam int OUT_W = ((9 * AXIS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        REG_PITCH_GAIN = 2'd0,
        REG_YAW_GAIN   = 2'd1,
        REG_ROLL_GAIN  = 2'd2,
        REG_UNUSED     = 2'd3
    } gain_reg_e;

    typedef struct packed {
        logic signed [15:0] dz;
        logic signed [15:0] dy;
        logic signed [15:0] dx;
    } motion_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [47:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    euler_orientation_axes_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] gain_pitch, gain_yaw, gain_roll;
    logic [15:0] ang_pitch, ang_yaw, ang_roll;

    motion_t motion_q[$];
    logic [OUT_W-1:0] axes_q[$];
    int errors;
    int in_gap;
    int out_gap;
    logic feeding;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return asr(a * b, 30);
    endfunction

    function automatic logic [15:0] step_angle(logic [15:0] ang, logic signed [15:0] d,
                                               logic [15:0] g);
        longint st;
        st = asr(longint'(d) * longint'({1'b0, g}), 8);
        return ang - st[15:0];
    endfunction

    task automatic half_sin_cos(input logic [15:0] ang, output longint s, output longint c);
        longint ph, x, y, z, nx;
        logic quad;
        ph = longint'(ang) << 15;
        quad = ph >= longint'(ONE_Q30);
        z = quad ? ph - longint'(ONE_Q30) : ph;
        x = longint'(ROT_GAIN);
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - asr(y, i);
                y = y + asr(x, i);
                z = z - longint'(atan_lut(i[4:0]));
            end
            else
            begin
                nx = x + asr(y, i);
                y = y - asr(x, i);
                z = z + longint'(atan_lut(i[4:0]));
            end
            x = nx;
        end
        if (quad)
        begin
            s = x;
            c = -y;
        end
        else
        begin
            s = y;
            c = x;
        end
    endtask

    function automatic logic [15:0] to_axis(longint v);
        longint r;
        r = asr(v + (longint'(1) << 15), 16);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    task automatic predict_axes(input motion_t m, output logic [OUT_W-1:0] res);
        longint sp, cp, sy, cy, sr, cr, w, x, y, z;
        longint x2, y2, z2, xy, xz, yz, wx, wy, wz, one;
        one = longint'(ONE_Q30);
        ang_pitch = step_angle(ang_pitch, m.dy, gain_pitch);
        ang_yaw = step_angle(ang_yaw, m.dx, gain_yaw);
        ang_roll = step_angle(ang_roll, m.dz, gain_roll);
        half_sin_cos(ang_pitch, sp, cp);
        half_sin_cos(ang_yaw, sy, cy);
        half_sin_cos(ang_roll, sr, cr);
        w = qmul(qmul(cr, cy), cp) + qmul(qmul(sr, sy), sp);
        x = qmul(qmul(sr, cy), cp) - qmul(qmul(cr, sy), sp);
        y = qmul(qmul(cr, sy), cp) + qmul(qmul(sr, cy), sp);
        z = qmul(qmul(cr, cy), sp) - qmul(qmul(sr, sy), cp);
        x2 = qmul(x, x); y2 = qmul(y, y); z2 = qmul(z, z);
        xy = qmul(x, y); xz = qmul(x, z); yz = qmul(y, z);
        wx = qmul(w, x); wy = qmul(w, y); wz = qmul(w, z);
        res = '0;
        res[15:0]    = to_axis(one - 2 * (y2 + z2));
        res[31:16]   = to_axis(2 * (xy + wz));
        res[47:32]   = to_axis(2 * (xz - wy));
        res[63:48]   = to_axis(2 * (xy - wz));
        res[79:64]   = to_axis(one - 2 * (x2 + z2));
        res[95:80]   = to_axis(2 * (yz + wx));
        res[111:96]  = to_axis(2 * (xz + wy));
        res[127:112] = to_axis(2 * (yz - wx));
        res[143:128] = to_axis(one - 2 * (x2 + y2));
    endtask

    task automatic report_mismatch(input string what, input int idx, input int got,
                                   input int want);
        $display("MISMATCH %s entry %0d: got %0d want %0d", what, idx, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_W-1:0] r;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            in_gap <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
        end
        else
        begin
            if (s_tvalid)
            begin
                predict_axes(motion_t'(s_tdata), r);
                axes_q.push_back(r);
            end
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (feeding && motion_q.size() > 0)
            begin
                s_tdata <= motion_q.pop_front();
                s_tvalid <= 1'b1;
                in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_W-1:0] want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (axes_q.size() == 0)
                begin
                    report_mismatch("unexpected", 0, 0, 0);
                end
                else
                begin
                    want = axes_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (m_tdata[k*16 +: 16] !== want[k*16 +: 16])
                            report_mismatch("axis", k, $signed(m_tdata[k*16 +: 16]),
                                            $signed(want[k*16 +: 16]));
                end
                out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_gain(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PITCH_GAIN: gain_pitch = val;
            REG_YAW_GAIN:   gain_yaw = val;
            REG_ROLL_GAIN:  gain_roll = val;
            default: ;
        endcase
    endtask

    // push a batch, let it all come back, then allow the core to settle
    task automatic run_batch(input int n, input logic directed_mix);
        motion_t m;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, directed_mix ? 3 : 0))
                0: m = motion_t'(48'({$urandom, $urandom}));
                1: m = '{dz: 16'sh8000, dy: 16'sh7fff, dx: 16'sh8000};
                2: m = motion_t'({16'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 64)),
                                  16'($urandom_range(0, 64))});
                default: m = '{dz: 16'($urandom_range(0, 7) - 4), dy: 16'sd1,
                               dx: -16'sd1};
            endcase
            motion_q.push_back(m);
        end
        feeding = 1'b1;
        wait (motion_q.size() == 0 && !s_tvalid && axes_q.size() == 0);
        feeding = 1'b0;
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        motion_t d;
        errors = 0;
        feeding = 1'b0;
        gain_pitch = 16'd256;
        gain_yaw = 16'd256;
        gain_roll = 16'd256;
        ang_pitch = '0;
        ang_yaw = '0;
        ang_roll = '0;
        cfg_we = 1'b0;
        cfg_index = REG_PITCH_GAIN;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and other fixed values at reset gains
        motion_q.push_back('{dz: 16'sd0, dy: 16'sd0, dx: 16'sd0});
        motion_q.push_back('{dz: 16'sh7fff, dy: 16'sh7fff, dx: 16'sh7fff});
        motion_q.push_back('{dz: 16'sh8000, dy: 16'sh8000, dx: 16'sh8000});
        motion_q.push_back('{dz: -16'sd1, dy: -16'sd1, dx: -16'sd1});
        motion_q.push_back('{dz: 16'sd1, dy: 16'sd128, dx: 16'sh4000});
        for (int i = 0; i < 4; i++)
            motion_q.push_back('{dz: 16'sh4000, dy: 16'sh4000, dx: 16'sh4000});
        run_batch(0, 1'b0);

        // zero gains: angles must hold
        write_gain(REG_PITCH_GAIN, 16'd0);
        write_gain(REG_YAW_GAIN, 16'd0);
        write_gain(REG_ROLL_GAIN, 16'd0);
        write_gain(REG_UNUSED, 16'hffff);
        run_batch(4, 1'b1);

        // maximum gains, heavy wrapping
        write_gain(REG_PITCH_GAIN, 16'hffff);
        write_gain(REG_YAW_GAIN, 16'hffff);
        write_gain(REG_ROLL_GAIN, 16'hffff);
        d = '{dz: 16'sh8000, dy: 16'sh8000, dx: 16'sh8000};
        motion_q.push_back(d);
        motion_q.push_back('{dz: 16'sh7fff, dy: 16'sh7fff, dx: 16'sh7fff});
        run_batch(200, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            write_gain(REG_PITCH_GAIN, 16'($urandom));
            write_gain(REG_YAW_GAIN, 16'($urandom));
            write_gain(REG_ROLL_GAIN, 16'($urandom_range(0, 1024)));
            write_gain(REG_UNUSED, 16'($urandom));
            run_batch(200, 1'b1);
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

[filelist.f]
rtl/eoa_pkg.sv
rtl/eoa_ctrl.sv
rtl/eoa_datapath.sv
rtl/euler_orientation_axes_core.sv
tb/sv/tb_euler_orientation_axes_core.sv
